FILE: hw/rtl/hmkil_pkg.sv
// ----------------------------------------------------------------------------
// hmkil_pkg
// Types and constants shared by the key index lookup block.
// ----------------------------------------------------------------------------
package hmkil_pkg;

	localparam int MAX_KEYS   = 1024;
	localparam int MAX_SUFFIX = 32;
	localparam int MAX_PREFIX = 32;
	localparam int MAX_QUERY  = 64;

	localparam int KEY_AW = $clog2(MAX_KEYS * MAX_SUFFIX);
	localparam int QRY_AW = $clog2(MAX_QUERY);
	localparam int POS_W  = $clog2(MAX_SUFFIX);

	typedef enum logic [1:0] {
		OP_PREFIX = 2'd0,
		OP_HOLE   = 2'd1,
		OP_TABLE  = 2'd2,
		OP_QUERY  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		REG_PREFIX_LEN = 2'd0,
		REG_SUFFIX_LEN = 2'd1,
		REG_STORED_LEN = 2'd2,
		REG_KEY_COUNT  = 2'd3
	} reg_idx_t;

	typedef struct packed {
		op_t        op;
		logic [9:0] key_slot;
		logic [4:0] byte_pos;
		logic [7:0] data_byte;
		logic       hole_mark;
		logic       query_mode;
		logic       last;
	} item_t;

	typedef struct packed {
		logic [5:0]  prefix_len;
		logic [5:0]  tail_len;
		logic [5:0]  stored_len;
		logic [10:0] key_count;
	} cfg_t;

endpackage

FILE: hw/rtl/hmkil_in_if.sv
// ----------------------------------------------------------------------------
// hmkil_in_if
// Input channel: load and query beats.
// ----------------------------------------------------------------------------
interface hmkil_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] operation;
	logic [9:0] key_slot;
	logic [4:0] byte_pos;
	logic [7:0] data_byte;
	logic       hole_mark;
	logic       query_mode;
	logic       last;

	modport source (output valid, operation, key_slot, byte_pos, data_byte, hole_mark,
		query_mode, last, input ready);
	modport sink (input valid, operation, key_slot, byte_pos, data_byte, hole_mark,
		query_mode, last, output ready);
endinterface

FILE: hw/rtl/hmkil_out_if.sv
// ----------------------------------------------------------------------------
// hmkil_out_if
// Output channel: one beat per answered query.
// ----------------------------------------------------------------------------
interface hmkil_out_if;
	logic        valid;
	logic        ready;
	logic        found;
	logic [10:0] rank;

	modport source (output valid, found, rank, input ready);
	modport sink (input valid, found, rank, output ready);
endinterface

FILE: hw/rtl/hole_masked_key_index_lookup.sv
// ----------------------------------------------------------------------------
// hole_masked_key_index_lookup
// Sorted fixed-length key table with shared prefix and stripped hole bytes,
// answering exact-find and lower-bound rank queries.
// ----------------------------------------------------------------------------
// Load beats (prefix byte, hole entry, table byte) and query bytes without
// the last flag are taken at one per cycle through a four-entry queue while
// no query is being answered. A query byte with the last flag starts the
// search: the prefix check and, for finds, the hole check compare one byte
// per step, and each binary-search probe, like the final equality compare,
// steps through the compared suffix bytes. Over 1024 keys the search runs up
// to eleven probes. The key memory is read one byte per compare step. The
// answer waits in an output register while new beats queue up.
module hole_masked_key_index_lookup
	import hmkil_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	hmkil_in_if.sink    in_ch,
	hmkil_out_if.source out_ch,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [10:0] cfg_data
);

	logic [5:0]  prefix_len_q;
	logic [5:0]  tail_len_q;
	logic [5:0]  stored_len_q;
	logic [10:0] key_count_q;
	cfg_t        cfg;
	logic        pop;
	logic        q_valid;
	item_t       q_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_len_q <= 6'd0;
			tail_len_q   <= 6'd1;
			stored_len_q <= 6'd1;
			key_count_q  <= 11'd0;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_PREFIX_LEN: prefix_len_q <= cfg_data[5:0];
				REG_SUFFIX_LEN: tail_len_q   <= cfg_data[5:0];
				REG_STORED_LEN: stored_len_q <= cfg_data[5:0];
				REG_KEY_COUNT:  key_count_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.prefix_len = (prefix_len_q > 6'(MAX_PREFIX)) ? 6'(MAX_PREFIX) : prefix_len_q;
		cfg.tail_len   = (tail_len_q > 6'(MAX_SUFFIX)) ? 6'(MAX_SUFFIX) : tail_len_q;
		cfg.stored_len = (stored_len_q > 6'(MAX_SUFFIX)) ? 6'(MAX_SUFFIX) : stored_len_q;
		cfg.key_count  = (key_count_q > 11'(MAX_KEYS)) ? 11'(MAX_KEYS) : key_count_q;
	end

	hmkil_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.pop     (pop),
		.q_valid (q_valid),
		.q_item  (q_item)
	);

	hmkil_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.q_valid (q_valid),
		.q_item  (q_item),
		.pop     (pop),
		.out_ch  (out_ch)
	);

	a_miss_rank_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.found |-> out_ch.rank == 11'd0)
		else $error("miss reported with a nonzero rank");

	a_rank_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> out_ch.rank <= cfg.key_count)
		else $error("rank beyond the key count");

endmodule

FILE: hw/rtl/hmkil_front.sv
// ----------------------------------------------------------------------------
// hmkil_front
// Accepts input beats, decodes the operation and queues them for the back end.
// ----------------------------------------------------------------------------
module hmkil_front
	import hmkil_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	hmkil_in_if.sink   in_ch,
	input  logic       pop,
	output logic       q_valid,
	output item_t      q_item
);

	localparam int DEPTH = 4;
	localparam int PW    = $clog2(DEPTH);

	item_t           fifo_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [PW:0]     count_q;
	logic            push;
	logic            do_pop;
	item_t           item_in;

	assign in_ch.ready = (count_q != (PW+1)'(DEPTH));
	assign push        = in_ch.valid && in_ch.ready;
	assign q_valid     = (count_q != '0);
	assign do_pop      = pop && q_valid;
	assign q_item      = fifo_q[rd_ptr_q];

	always_comb begin
		item_in.op         = op_t'(in_ch.operation);
		item_in.key_slot   = in_ch.key_slot;
		item_in.byte_pos   = in_ch.byte_pos;
		item_in.data_byte  = in_ch.data_byte;
		item_in.hole_mark  = in_ch.hole_mark;
		item_in.query_mode = in_ch.query_mode;
		item_in.last       = in_ch.last;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			if (push && !do_pop) begin
				count_q <= count_q + (PW+1)'(1);
			end else if (!push && do_pop) begin
				count_q <= count_q - (PW+1)'(1);
			end
		end
	end

endmodule

FILE: hw/rtl/hmkil_back.sv
// ----------------------------------------------------------------------------
// hmkil_back
// Executes queued beats: table loads, query buffering and the byte-serial
// prefix check, hole check and lower-bound binary search.
// ----------------------------------------------------------------------------
module hmkil_back
	import hmkil_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        q_valid,
	input  item_t       q_item,
	output logic        pop,
	hmkil_out_if.source out_ch
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_PFX,
		S_HOLE,
		S_SEARCH,
		S_PROBE,
		S_FINAL,
		S_OUT
	} state_t;

	state_t      state_q;
	logic        ph_q;
	logic [5:0]  i_q;
	logic [5:0]  j_q;
	logic [5:0]  len_q;
	logic [9:0]  k_q;
	logic [10:0] lo_q;
	logic [10:0] hi_q;
	logic        mode_q;
	logic [6:0]  l_q;
	logic        tlt_q;
	logic        tgt_q;
	logic        bad_q;
	logic [6:0]  qlen_q;
	logic        ovl_q;
	logic        res_found_q;
	logic [10:0] res_rank_q;
	logic        out_valid_q;
	logic        out_found_q;
	logic [10:0] out_rank_q;

	logic [7:0]  qbuf_mem [MAX_QUERY];
	logic [7:0]  key_mem [MAX_KEYS * MAX_SUFFIX];
	logic [7:0]  prefix_store [MAX_PREFIX];
	logic        hole_flag [MAX_SUFFIX];
	logic [7:0]  hole_val [MAX_SUFFIX];
	logic [7:0]  qrd_q;
	logic [7:0]  krd_q;

	logic              qfull;
	logic [6:0]        new_len;
	logic              new_ovl;
	logic [6:0]        new_l;
	logic [6:0]        full_len;
	logic [QRY_AW-1:0] qaddr;
	logic [6:0]        s_len;
	logic              s_gt;
	logic [5:0]        probe_len;
	logic [11:0]       mid_sum;
	logic [POS_W-1:0]  ix;
	logic [7:0]        tb;
	logic              is_hole;

	assign pop      = (state_q == S_IDLE) && q_valid;
	assign qfull    = (qlen_q == 7'(MAX_QUERY));
	assign new_len  = qfull ? qlen_q : qlen_q + 7'd1;
	assign new_ovl  = ovl_q || qfull;
	assign new_l    = new_len + {6'd0, new_ovl};
	assign full_len = {1'b0, cfg.prefix_len} + {1'b0, cfg.tail_len};
	assign s_len    = l_q - {1'b0, cfg.prefix_len};
	assign s_gt     = (s_len > {1'b0, cfg.tail_len});
	assign probe_len = (mode_q && !s_gt) ? s_len[5:0] : cfg.tail_len;
	assign mid_sum  = {1'b0, lo_q} + {1'b0, hi_q};
	assign ix       = i_q[POS_W-1:0];
	assign qaddr    = (state_q == S_PFX) ? i_q[QRY_AW-1:0]
		: QRY_AW'(cfg.prefix_len) + QRY_AW'(i_q);
	assign is_hole  = hole_flag[ix];

	always_comb begin
		if (state_q == S_PFX) begin
			tb = prefix_store[ix];
		end else if (is_hole) begin
			tb = hole_val[ix];
		end else if (j_q < cfg.stored_len) begin
			tb = krd_q;
		end else begin
			tb = 8'd0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && q_item.op == OP_QUERY && !qfull) begin
			qbuf_mem[qlen_q[QRY_AW-1:0]] <= q_item.data_byte;
		end
		qrd_q <= qbuf_mem[qaddr];
	end

	always_ff @(posedge clk) begin
		if (pop && q_item.op == OP_TABLE) begin
			key_mem[{q_item.key_slot, q_item.byte_pos}] <= q_item.data_byte;
		end
		krd_q <= key_mem[{k_q, j_q[POS_W-1:0]}];
	end

	always_ff @(posedge clk) begin
		if (pop && q_item.op == OP_PREFIX) begin
			prefix_store[q_item.byte_pos] <= q_item.data_byte;
		end
		if (pop && q_item.op == OP_HOLE) begin
			hole_flag[q_item.byte_pos] <= q_item.hole_mark;
			hole_val[q_item.byte_pos]  <= q_item.data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ph_q        <= 1'b0;
			i_q         <= '0;
			j_q         <= '0;
			len_q       <= '0;
			k_q         <= '0;
			lo_q        <= '0;
			hi_q        <= '0;
			mode_q      <= 1'b0;
			l_q         <= '0;
			tlt_q       <= 1'b0;
			tgt_q       <= 1'b0;
			bad_q       <= 1'b0;
			qlen_q      <= '0;
			ovl_q       <= 1'b0;
			res_found_q <= 1'b0;
			res_rank_q  <= '0;
			out_valid_q <= 1'b0;
			out_found_q <= 1'b0;
			out_rank_q  <= '0;
		end else begin
			if (out_valid_q && out_ch.ready && state_q != S_OUT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (pop && q_item.op == OP_QUERY) begin
						if (!q_item.last) begin
							qlen_q <= new_len;
							ovl_q  <= new_ovl;
						end else begin
							qlen_q <= '0;
							ovl_q  <= 1'b0;
							l_q    <= new_l;
							mode_q <= q_item.query_mode;
							i_q    <= '0;
							ph_q   <= 1'b0;
							tlt_q  <= 1'b0;
							tgt_q  <= 1'b0;
							if (!q_item.query_mode) begin
								if (new_ovl || new_l != full_len) begin
									res_found_q <= 1'b0;
									res_rank_q  <= '0;
									state_q     <= S_OUT;
								end else begin
									len_q   <= cfg.prefix_len;
									state_q <= S_PFX;
								end
							end else begin
								len_q   <= (new_l <= {1'b0, cfg.prefix_len})
									? new_l[5:0] : cfg.prefix_len;
								state_q <= S_PFX;
							end
						end
					end
				end
				S_PFX, S_HOLE, S_PROBE, S_FINAL: begin
					if (!ph_q) begin
						if (i_q != len_q) begin
							ph_q <= 1'b1;
						end else begin
							case (state_q)
								S_PFX: begin
									if (!mode_q) begin
										if (tlt_q || tgt_q) begin
											res_found_q <= 1'b0;
											res_rank_q  <= '0;
											state_q     <= S_OUT;
										end else begin
											i_q     <= '0;
											len_q   <= cfg.tail_len;
											bad_q   <= 1'b0;
											state_q <= S_HOLE;
										end
									end else if (l_q <= {1'b0, cfg.prefix_len}) begin
										res_found_q <= 1'b1;
										res_rank_q  <= tlt_q ? cfg.key_count : '0;
										state_q     <= S_OUT;
									end else if (tgt_q || tlt_q) begin
										res_found_q <= 1'b1;
										res_rank_q  <= tlt_q ? cfg.key_count : '0;
										state_q     <= S_OUT;
									end else begin
										lo_q    <= '0;
										hi_q    <= cfg.key_count;
										state_q <= S_SEARCH;
									end
								end
								S_HOLE: begin
									if (bad_q) begin
										res_found_q <= 1'b0;
										res_rank_q  <= '0;
										state_q     <= S_OUT;
									end else begin
										lo_q    <= '0;
										hi_q    <= cfg.key_count;
										state_q <= S_SEARCH;
									end
								end
								S_PROBE: begin
									if (tlt_q) begin
										lo_q <= {1'b0, k_q} + 11'd1;
									end else begin
										hi_q <= {1'b0, k_q};
									end
									state_q <= S_SEARCH;
								end
								default: begin
									res_found_q <= mode_q || (!tlt_q && !tgt_q);
									if (!mode_q) begin
										res_rank_q <= (!tlt_q && !tgt_q) ? lo_q : '0;
									end else begin
										res_rank_q <= lo_q + {10'd0, !tlt_q && !tgt_q};
									end
									state_q <= S_OUT;
								end
							endcase
						end
					end else begin
						ph_q <= 1'b0;
						if (state_q == S_HOLE) begin
							if (is_hole && hole_val[ix] != qrd_q) begin
								bad_q <= 1'b1;
								i_q   <= len_q;
							end else begin
								i_q <= i_q + 6'd1;
							end
						end else begin
							if (state_q != S_PFX && !is_hole) begin
								j_q <= j_q + 6'd1;
							end
							if (tb != qrd_q) begin
								tlt_q <= (tb < qrd_q);
								tgt_q <= (tb > qrd_q);
								i_q   <= len_q;
							end else begin
								i_q <= i_q + 6'd1;
							end
						end
					end
				end
				S_SEARCH: begin
					i_q   <= '0;
					j_q   <= '0;
					ph_q  <= 1'b0;
					tlt_q <= 1'b0;
					tgt_q <= 1'b0;
					if (lo_q < hi_q) begin
						k_q     <= mid_sum[10:1];
						len_q   <= probe_len;
						state_q <= S_PROBE;
					end else if (lo_q < cfg.key_count && (!mode_q || s_gt)) begin
						k_q     <= lo_q[9:0];
						len_q   <= cfg.tail_len;
						state_q <= S_FINAL;
					end else begin
						res_found_q <= mode_q;
						res_rank_q  <= mode_q ? lo_q : '0;
						state_q     <= S_OUT;
					end
				end
				S_OUT: begin
					if (!out_valid_q || out_ch.ready) begin
						out_valid_q <= 1'b1;
						out_found_q <= res_found_q;
						out_rank_q  <= res_rank_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.found = out_found_q;
	assign out_ch.rank  = out_rank_q;

endmodule
